// ===== rtl/cartesian_to_spherical_defines.svh =====
// ----------------------------------------------------------------------------
// cartesian_to_spherical_defines
// assertion macros used by the checker of the conversion block
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_SPHERICAL_DEFINES_SVH
`define CARTESIAN_TO_SPHERICAL_DEFINES_SVH

// same-cycle implication on clk, off while reset is low
`define C2S_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication that checks the consequent after the full pipeline latency
`define C2S_ASSERT_LATENCY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> ##TOTAL_LAT (cons)) else $error(msg);

`endif

// ===== rtl/c2s_pkg.sv =====
// ----------------------------------------------------------------------------
// c2s_pkg
// widths, latencies, payload types and the arctangent table of the
// cartesian to spherical conversion pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c2s_pkg;

  localparam int COORD_BITS    = 24;
  localparam int CORDIC_STAGES = 24;
  localparam int RUN_STAGES    = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int ANGLE_BITS    = 24;
  localparam int GUARD_BITS    = 8;

  // sum of three squares of magnitudes up to 2^(COORD_BITS-1) stays below 2^SUM_BITS
  localparam int SUM_BITS      = 2 * COORD_BITS;
  // rotation operands: a coordinate or an unsigned hypot, one extra bit
  localparam int ARG_BITS      = COORD_BITS + 1;
  // guard shift plus cordic gain plus headroom
  localparam int CW_BITS       = COORD_BITS + 11;
  // angle accumulator, 2^31 = pi
  localparam int ACC_BITS      = 34;
  localparam int ANG_FULL_BITS = ACC_BITS - GUARD_BITS;

  localparam int FRONT_LAT     = 5;
  localparam int SQRT_LAT      = COORD_BITS + 1;
  localparam int CORDIC_LAT    = RUN_STAGES + 2;
  localparam int TOTAL_LAT     = FRONT_LAT + SQRT_LAT + CORDIC_LAT + 1;

  localparam logic signed [ACC_BITS-1:0] QUARTER_TURN = ACC_BITS'(64'sd1073741824);
  localparam logic signed [ACC_BITS-1:0] ROUND_HALF   = ACC_BITS'(1 << (GUARD_BITS - 1));
  localparam logic signed [ANGLE_BITS-1:0] LAT_LIMIT  = ANGLE_BITS'(1 << (ANGLE_BITS - 2));
  localparam logic signed [ANGLE_BITS-1:0] LAT_FLOOR  = -LAT_LIMIT;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic signed [COORD_BITS-1:0] z_coord;
  } point_t;

  typedef struct packed {
    logic        [COORD_BITS-1:0] radius;
    logic signed [ANGLE_BITS-1:0] longitude;
    logic signed [ANGLE_BITS-1:0] latitude;
  } result_t;

  // atan(2^-i), 2^31 = pi
  function automatic logic [30:0] atan_entry(input logic [4:0] idx);
    logic [30:0] val;
    case (idx)
      5'd0:    val = 31'd536870912;
      5'd1:    val = 31'd316933406;
      5'd2:    val = 31'd167458907;
      5'd3:    val = 31'd85004756;
      5'd4:    val = 31'd42667331;
      5'd5:    val = 31'd21354465;
      5'd6:    val = 31'd10679838;
      5'd7:    val = 31'd5340245;
      5'd8:    val = 31'd2670163;
      5'd9:    val = 31'd1335087;
      5'd10:   val = 31'd667544;
      5'd11:   val = 31'd333772;
      5'd12:   val = 31'd166886;
      5'd13:   val = 31'd83443;
      5'd14:   val = 31'd41721;
      5'd15:   val = 31'd20860;
      5'd16:   val = 31'd10430;
      5'd17:   val = 31'd5215;
      5'd18:   val = 31'd2607;
      5'd19:   val = 31'd1303;
      5'd20:   val = 31'd651;
      5'd21:   val = 31'd325;
      5'd22:   val = 31'd162;
      5'd23:   val = 31'd81;
      5'd24:   val = 31'd40;
      5'd25:   val = 31'd20;
      5'd26:   val = 31'd10;
      5'd27:   val = 31'd5;
      5'd28:   val = 31'd2;
      5'd29:   val = 31'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/c2s_sqrt.sv =====
// ----------------------------------------------------------------------------
// c2s_sqrt
// pipelined square root, one root bit per stage, rounded to nearest
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c2s_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [c2s_pkg::SUM_BITS-1:0]  in_sq,
  output logic                               out_valid,
  output logic      [c2s_pkg::COORD_BITS-1:0] out_root
);
  import c2s_pkg::*;

  localparam int STEPS = COORD_BITS;
  localparam int TW    = SUM_BITS + 1;

  typedef struct packed {
    logic [SUM_BITS-1:0]   rem;
    logic [COORD_BITS-1:0] root;
  } sq_state_t;

  // try to set root bit k: remainder is s - root^2
  function automatic sq_state_t sqrt_step(input sq_state_t cur, input int k);
    sq_state_t res;
    logic [TW-1:0] trial;
    trial = (TW'(cur.root) << (k + 1)) + (TW'(1) << (2 * k));
    res = cur;
    if ({1'b0, cur.rem} >= trial) begin
      res.rem  = cur.rem - trial[SUM_BITS-1:0];
      res.root = cur.root | (COORD_BITS'(1) << k);
    end
    return res;
  endfunction

  sq_state_t             seed;
  sq_state_t             st_r   [STEPS];
  sq_state_t             st_nxt [STEPS];
  logic [STEPS-1:0]      vld_r;
  logic                  out_vld_r;
  logic [COORD_BITS-1:0] root_r;
  logic [COORD_BITS-1:0] root_nxt;
  logic                  round_up;

  always_comb begin
    seed.rem  = in_sq;
    seed.root = '0;
    st_nxt[0] = sqrt_step(seed, STEPS - 1);
    for (int j = 1; j < STEPS; j++) begin
      st_nxt[j] = sqrt_step(st_r[j-1], STEPS - 1 - j);
    end
  end

  // remainder above the floor root means the exact root is past the half point
  assign round_up = st_r[STEPS-1].rem > SUM_BITS'(st_r[STEPS-1].root);
  assign root_nxt = st_r[STEPS-1].root + COORD_BITS'(round_up);

  always_ff @(posedge clk) begin
    for (int j = 0; j < STEPS; j++) begin
      st_r[j] <= st_nxt[j];
    end
    root_r <= root_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[STEPS-2:0], in_valid};
      out_vld_r <= vld_r[STEPS-1];
    end
  end

  assign out_valid = out_vld_r;
  assign out_root  = root_r;

endmodule

`default_nettype wire

// ===== rtl/c2s_cordic.sv =====
// ----------------------------------------------------------------------------
// c2s_cordic
// pipelined vectoring cordic: atan2(in_y, in_x), one rotation per stage,
// result rounded from 2^31 = pi down to 2^23 = pi
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c2s_cordic (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  input  wire logic signed [c2s_pkg::ARG_BITS-1:0]   in_y,
  input  wire logic signed [c2s_pkg::ARG_BITS-1:0]   in_x,
  output logic                                       out_valid,
  output logic signed [c2s_pkg::ANG_FULL_BITS-1:0]   out_angle
);
  import c2s_pkg::*;

  typedef struct packed {
    logic signed [CW_BITS-1:0]  xv;
    logic signed [CW_BITS-1:0]  yv;
    logic signed [ACC_BITS-1:0] acc;
  } rot_t;

  rot_t                              st_r   [RUN_STAGES+1];
  rot_t                              st_nxt [RUN_STAGES+1];
  logic [RUN_STAGES:0]               vld_r;
  logic                              out_vld_r;
  logic signed [ANG_FULL_BITS-1:0]   angle_r;
  logic signed [ANG_FULL_BITS-1:0]   angle_nxt;
  logic signed [ACC_BITS-1:0]        rnd;

  always_comb begin
    logic signed [CW_BITS-1:0] xs;
    logic signed [CW_BITS-1:0] ys;
    logic signed [CW_BITS-1:0] dx;
    logic signed [CW_BITS-1:0] dy;
    rot_t cur;
    rot_t nx;
    xs = CW_BITS'(in_x) <<< GUARD_BITS;
    ys = CW_BITS'(in_y) <<< GUARD_BITS;
    nx.xv  = xs;
    nx.yv  = ys;
    nx.acc = '0;
    // left half plane: quarter turn first so the rotations converge
    if (xs < 0) begin
      if (ys >= 0) begin
        nx.xv  = ys;
        nx.yv  = -xs;
        nx.acc = QUARTER_TURN;
      end else begin
        nx.xv  = -ys;
        nx.yv  = xs;
        nx.acc = -QUARTER_TURN;
      end
    end
    st_nxt[0] = nx;
    for (int i = 0; i < RUN_STAGES; i++) begin
      cur = st_r[i];
      dx  = cur.yv >>> i;
      dy  = cur.xv >>> i;
      if (!cur.yv[CW_BITS-1]) begin
        nx.xv  = cur.xv + dx;
        nx.yv  = cur.yv - dy;
        nx.acc = cur.acc + ACC_BITS'(atan_entry(5'(i)));
      end else begin
        nx.xv  = cur.xv - dx;
        nx.yv  = cur.yv + dy;
        nx.acc = cur.acc - ACC_BITS'(atan_entry(5'(i)));
      end
      st_nxt[i+1] = nx;
    end
  end

  // round half up, then floor shift
  assign rnd       = st_r[RUN_STAGES].acc + ROUND_HALF;
  assign angle_nxt = rnd[ACC_BITS-1:GUARD_BITS];

  always_ff @(posedge clk) begin
    for (int i = 0; i <= RUN_STAGES; i++) begin
      st_r[i] <= st_nxt[i];
    end
    angle_r <= angle_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[RUN_STAGES-1:0], in_valid};
      out_vld_r <= vld_r[RUN_STAGES];
    end
  end

  assign out_valid = out_vld_r;
  assign out_angle = angle_r;

endmodule

`default_nettype wire

// ===== rtl/cartesian_to_spherical.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// converts a signed point (x, y, z) into radius, longitude atan2(x, z) and
// latitude atan2(y, hypot(x, z)); angles in binary units, 2^23 = pi
// ----------------------------------------------------------------------------
// One request is taken per clock whenever busy is low; busy is high only
// during reset and the first cycle after it. Every result appears on
// out_result with out_valid high for exactly one cycle, in request order.
// Between request and result lie five front stages (input register,
// absolute values, squares, two sums), COORD_BITS + 1 stages of the
// bit-per-stage square roots for radius and hypot(x, z), RUN_STAGES + 2
// stages of the two parallel rotation pipelines, and one output register.
// The pipeline never stalls, so results must be taken in the cycle they are
// shown. A point at the origin gives an all-zero result.
`timescale 1ns / 1ps
`default_nettype none

module cartesian_to_spherical (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire c2s_pkg::point_t  in_point,
  output logic                  out_valid,
  output c2s_pkg::result_t      out_result
);
  import c2s_pkg::*;

  function automatic logic [COORD_BITS-1:0] mag(input logic [COORD_BITS-1:0] v);
    return v[COORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  logic                  busy_r;
  logic                  accept;
  logic [FRONT_LAT-1:0]  fv_r;

  point_t                pa_r, pb_r, pc_r, pd_r, pe_r;
  logic [COORD_BITS-1:0] ax_r, ay_r, az_r;
  logic [SUM_BITS-1:0]   sqx_nxt, sqy_nxt, sqz_nxt;
  logic [SUM_BITS-1:0]   sqx_r, sqy_r, sqz_r;
  logic [SUM_BITS-1:0]   xz_r, sqy_d_r, xz_e_r, all_r;

  logic                  rad_vld, hyp_vld;
  logic [COORD_BITS-1:0] rad, hyp;
  point_t                pdl_r [SQRT_LAT];
  point_t                pt;

  logic signed [ARG_BITS-1:0]      lon_y, lon_x, lat_y, lat_x;
  logic                            lon_vld, lat_vld;
  logic signed [ANG_FULL_BITS-1:0] lon_ang, lat_ang;
  logic [COORD_BITS-1:0]           rdl_r [CORDIC_LAT];

  logic signed [ANGLE_BITS-1:0]    lat_cl;
  result_t                         res_nxt;
  result_t                         res_r;
  logic                            out_vld_r;

  assign accept = start & ~busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      fv_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= 1'b0;
      fv_r      <= {fv_r[FRONT_LAT-2:0], accept};
      out_vld_r <= lon_vld & lat_vld;
    end
  end

  assign sqx_nxt = ax_r * ax_r;
  assign sqy_nxt = ay_r * ay_r;
  assign sqz_nxt = az_r * az_r;

  // front stages: capture, magnitudes, squares, x^2+z^2, full sum
  always_ff @(posedge clk) begin
    pa_r    <= in_point;
    pb_r    <= pa_r;
    ax_r    <= mag(pa_r.x_coord);
    ay_r    <= mag(pa_r.y_coord);
    az_r    <= mag(pa_r.z_coord);
    pc_r    <= pb_r;
    sqx_r   <= sqx_nxt;
    sqy_r   <= sqy_nxt;
    sqz_r   <= sqz_nxt;
    pd_r    <= pc_r;
    xz_r    <= sqx_r + sqz_r;
    sqy_d_r <= sqy_r;
    pe_r    <= pd_r;
    xz_e_r  <= xz_r;
    all_r   <= xz_r + sqy_d_r;
  end

  c2s_sqrt u_sqrt_rad (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fv_r[FRONT_LAT-1]),
    .in_sq     (all_r),
    .out_valid (rad_vld),
    .out_root  (rad)
  );

  c2s_sqrt u_sqrt_hyp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fv_r[FRONT_LAT-1]),
    .in_sq     (xz_e_r),
    .out_valid (hyp_vld),
    .out_root  (hyp)
  );

  // coordinates wait out the square roots
  always_ff @(posedge clk) begin
    pdl_r[0] <= pe_r;
    for (int k = 1; k < SQRT_LAT; k++) begin
      pdl_r[k] <= pdl_r[k-1];
    end
  end

  assign pt    = pdl_r[SQRT_LAT-1];
  assign lon_y = ARG_BITS'(pt.x_coord);
  assign lon_x = ARG_BITS'(pt.z_coord);
  assign lat_y = ARG_BITS'(pt.y_coord);
  assign lat_x = $signed({1'b0, hyp});

  c2s_cordic u_cordic_lon (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rad_vld),
    .in_y      (lon_y),
    .in_x      (lon_x),
    .out_valid (lon_vld),
    .out_angle (lon_ang)
  );

  c2s_cordic u_cordic_lat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hyp_vld),
    .in_y      (lat_y),
    .in_x      (lat_x),
    .out_valid (lat_vld),
    .out_angle (lat_ang)
  );

  // radius waits out the rotations
  always_ff @(posedge clk) begin
    rdl_r[0] <= rad;
    for (int k = 1; k < CORDIC_LAT; k++) begin
      rdl_r[k] <= rdl_r[k-1];
    end
  end

  always_comb begin
    if (lat_ang > LAT_LIMIT) begin
      lat_cl = LAT_LIMIT;
    end else if (lat_ang < LAT_FLOOR) begin
      lat_cl = LAT_FLOOR;
    end else begin
      lat_cl = lat_ang[ANGLE_BITS-1:0];
    end
    // truncation wraps a longitude of +pi onto -pi
    res_nxt.radius    = rdl_r[CORDIC_LAT-1];
    res_nxt.longitude = lon_ang[ANGLE_BITS-1:0];
    res_nxt.latitude  = lat_cl;
    if (rdl_r[CORDIC_LAT-1] == '0) begin
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid  = out_vld_r;
  assign out_result = res_r;

endmodule

`default_nettype wire

// ===== rtl/c2s_checker.sv =====
// ----------------------------------------------------------------------------
// c2s_checker
// port-level checks of the conversion pipeline, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cartesian_to_spherical_defines.svh"

module c2s_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire c2s_pkg::point_t   in_point,
  input wire logic              out_valid,
  input wire c2s_pkg::result_t  out_result
);
  import c2s_pkg::*;

  // every result goes back to a request the full pipeline latency earlier
  `C2S_ASSERT_SAME(a_result_has_request, out_valid, $past(start && !busy, TOTAL_LAT), "result without request")

  // each request produces its result after the full pipeline latency
  `C2S_ASSERT_LATENCY(a_request_gives_result, start && !busy, out_valid, "request lost")

  // origin maps to an all-zero result
  `C2S_ASSERT_LATENCY(a_origin_zero, start && !busy && in_point == '0, out_valid && out_result == '0, "origin not zero")

  // a zero radius carries zero angles
  `C2S_ASSERT_SAME(a_zero_radius_angles, out_valid && out_result.radius == '0, out_result.longitude == '0 && out_result.latitude == '0, "angles on zero radius")

  // latitude stays within the poles
  `C2S_ASSERT_SAME(a_lat_range, out_valid, out_result.latitude <= LAT_LIMIT && out_result.latitude >= LAT_FLOOR, "latitude out of range")

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (.*);

`default_nettype wire
